/* hw/rtl/bla_pkg.sv */
// ----------------------------------------------------------------------------
// bla_pkg: shared types and constants of the battery low voltage alarm
// Payload structs, register indexes, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bla_pkg;

  localparam int MEASURE_DIVIDE_DEF = 20;
  localparam int STARTUP_TICKS_DEF  = 500;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_SCALE   = 8'd1;

  localparam logic [15:0] THRESHOLD_RST = 16'd10240;
  localparam logic [15:0] SCALE_RST     = 16'd45056;

  // Operand width of the shared multiplier and the reciprocal of five.
  // floor(n * RECIP5 / 2^21) equals floor(n / 5) for every n below 699050.
  localparam int          MUL_W      = 19;
  localparam int          PROD_W     = 2 * MUL_W;
  localparam int          RECIP_SHIFT = 21;
  localparam logic [MUL_W-1:0] RECIP5 = 19'd419431;

  localparam logic [17:0] BATT_OFFSET_Q10 = 18'd338;
  localparam logic [15:0] BATT_LOW_Q10    = 16'd7168;
  localparam logic [16:0] HYST_Q10        = 17'd205;
  // 2 (rounding) + 327680 (keeps the dividend positive) - 4464 (279 degrees).
  localparam logic [20:0] TEMP_BIAS       = 21'd323218;
  localparam logic [4:0]  ALARM_FULL      = 5'd20;

  typedef struct packed {
    logic [15:0] battery_pin;
    logic [15:0] temp_pin;
  } in_t;

  typedef struct packed {
    logic               measured;
    logic [15:0]        battery_volts;
    logic signed [15:0] chip_temp;
    logic               beeper;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BDIV,
    ST_TDIV,
    ST_ALARM,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/bla_mul.sv */
// ----------------------------------------------------------------------------
// bla_mul: shared multiplier
// Unsigned multiplier with a registered product, reused for the battery scale
// and for both divide-by-five steps of the filters.
// ----------------------------------------------------------------------------
`default_nettype none

module bla_mul (
  input  wire logic                        clk,
  input  wire logic [bla_pkg::MUL_W-1:0]  op_a,
  input  wire logic [bla_pkg::MUL_W-1:0]  op_b,
  output logic      [bla_pkg::PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= bla_pkg::PROD_W'(op_a) * bla_pkg::PROD_W'(op_b);
  end

endmodule

`default_nettype wire

/* hw/rtl/bla_tick.sv */
// ----------------------------------------------------------------------------
// bla_tick: tick prescaler and startup counter
// Divides the ticks and flags the ticks that take a measurement.
// ----------------------------------------------------------------------------
`default_nettype none

module bla_tick #(
  parameter int MEASURE_DIVIDE = bla_pkg::MEASURE_DIVIDE_DEF,
  parameter int STARTUP_TICKS  = bla_pkg::STARTUP_TICKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic advance,
  output logic      measure
);

  localparam int PW = $clog2(MEASURE_DIVIDE + 1);
  localparam int SW = $clog2(STARTUP_TICKS + 2);

  logic [PW-1:0] prescale_r, prescale_nxt, prescale_inc;
  logic [SW-1:0] startup_r, startup_nxt;
  logic          wrap;

  always_comb begin
    prescale_inc = prescale_r + PW'(1);
    wrap         = (prescale_inc >= PW'(MEASURE_DIVIDE));
    if (startup_r < SW'(STARTUP_TICKS + 1)) begin
      startup_nxt = startup_r + SW'(1);
    end else begin
      startup_nxt = startup_r;
    end
    prescale_nxt = wrap ? '0 : prescale_inc;
    measure      = wrap && (startup_nxt > SW'(STARTUP_TICKS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= '0;
      startup_r  <= '0;
    end else if (advance) begin
      prescale_r <= prescale_nxt;
      startup_r  <= startup_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/battery_low_voltage_alarm.sv */
// ----------------------------------------------------------------------------
// battery_low_voltage_alarm: filtered battery and temperature with alarm
// Every item is one tick; measurement ticks filter both pins and run the
// low battery alarm that toggles the beeper.
//
//   channel | ports                        | dir | payload
//   in      | in_valid in_ready in_data    | in  | bla_pkg::in_t
//   out     | out_valid out_ready out_data | out | bla_pkg::out_t
//   cfg     | cfg_valid cfg_ready cfg_*    | in  | register index and data
//
// A measurement tick makes three passes through the one shared multiplier
// (scale, then two reciprocal divisions by five) before the alarm update.
// The result sits in an output register; a new item is taken while it waits.
// Reset is synchronous and restores all registers but the payload registers;
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_low_voltage_alarm #(
  parameter int MEASURE_DIVIDE = bla_pkg::MEASURE_DIVIDE_DEF,
  parameter int STARTUP_TICKS  = bla_pkg::STARTUP_TICKS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire bla_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output bla_pkg::out_t                        out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bla_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bla_pkg::state_t state_r, state_nxt;

  logic [15:0] thr_r, scale_r;
  logic [15:0] tpin_r;
  logic [15:0] fb_r, fb_nxt;
  logic [15:0] ft_r, ft_nxt;
  logic [4:0]  cnt_r, cnt_nxt, cnt_inc;
  logic        beep_r, beep_nxt;
  logic        meas_r;
  logic        out_valid_r, out_valid_nxt;
  bla_pkg::out_t out_data_r;

  logic accept, measure, emit;
  logic [bla_pkg::MUL_W-1:0]  op_a, op_b;
  logic [bla_pkg::PROD_W-1:0] prod_r;

  logic [32:0] prod_round;
  logic [17:0] bsample_raw;
  logic [15:0] bsample;
  logic [18:0] bnum;
  logic [20:0] t25;
  logic [14:0] t6;
  logic [20:0] tnum;
  logic [15:0] quot;
  logic [16:0] clear_level;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == bla_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bla_tick #(
    .MEASURE_DIVIDE (MEASURE_DIVIDE),
    .STARTUP_TICKS  (STARTUP_TICKS)
  ) u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .measure (measure)
  );

  bla_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Sample arithmetic feeding the multiplier, its quotient and the alarm levels.
  always_comb begin
    prod_round  = {1'b0, prod_r[31:0]} + 33'd32768;
    bsample_raw = {1'b0, prod_round[32:16]} + bla_pkg::BATT_OFFSET_Q10;
    bsample     = (bsample_raw > 18'd65535) ? 16'hFFFF : bsample_raw[15:0];
    bnum        = {1'b0, fb_r, 2'b00} + {3'b000, bsample} + 19'd2;
    t25         = {1'b0, tpin_r, 4'b0000} + {2'b00, tpin_r, 3'b000}
                + {5'b00000, tpin_r} + 21'd32;
    t6          = t25[20:6];
    tnum        = {{3{ft_r[15]}}, ft_r, 2'b00} + {6'b000000, t6} + bla_pkg::TEMP_BIAS;
    quot        = prod_r[bla_pkg::RECIP_SHIFT+15:bla_pkg::RECIP_SHIFT];
    clear_level = {1'b0, thr_r} + bla_pkg::HYST_Q10;
    cnt_inc     = (cnt_r < bla_pkg::ALARM_FULL) ? cnt_r + 5'd1 : cnt_r;
  end

  // Sequencer: operand select, next state and state updates.
  always_comb begin
    state_nxt     = state_r;
    fb_nxt        = fb_r;
    ft_nxt        = ft_r;
    cnt_nxt       = cnt_r;
    beep_nxt      = beep_r;
    out_valid_nxt = out_valid_r;
    emit          = 1'b0;
    op_a          = '0;
    op_b          = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      bla_pkg::ST_IDLE: begin
        op_a = {3'b000, in_data.battery_pin};
        op_b = {3'b000, scale_r};
        if (accept) begin
          state_nxt = measure ? bla_pkg::ST_BDIV : bla_pkg::ST_EMIT;
        end
      end
      bla_pkg::ST_BDIV: begin
        op_a      = bnum;
        op_b      = bla_pkg::RECIP5;
        state_nxt = bla_pkg::ST_TDIV;
      end
      bla_pkg::ST_TDIV: begin
        op_a      = tnum[18:0];
        op_b      = bla_pkg::RECIP5;
        fb_nxt    = quot;
        state_nxt = bla_pkg::ST_ALARM;
      end
      bla_pkg::ST_ALARM: begin
        ft_nxt = quot;
        if ((fb_r > bla_pkg::BATT_LOW_Q10) && (fb_r < thr_r)) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= bla_pkg::ALARM_FULL) begin
            beep_nxt = ~beep_r;
          end
        end else if ({1'b0, fb_r} > clear_level) begin
          cnt_nxt  = '0;
          beep_nxt = 1'b0;
        end
        state_nxt = bla_pkg::ST_EMIT;
      end
      bla_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          emit          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bla_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bla_pkg::ST_IDLE;
      thr_r       <= bla_pkg::THRESHOLD_RST;
      scale_r     <= bla_pkg::SCALE_RST;
      fb_r        <= '0;
      ft_r        <= '0;
      cnt_r       <= '0;
      beep_r      <= 1'b0;
      meas_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fb_r        <= fb_nxt;
      ft_r        <= ft_nxt;
      cnt_r       <= cnt_nxt;
      beep_r      <= beep_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        meas_r <= measure;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bla_pkg::CFG_ALARM_THRESHOLD) begin
          thr_r <= cfg_data;
        end else if (cfg_index == bla_pkg::CFG_VOLTAGE_SCALE) begin
          scale_r <= cfg_data;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      tpin_r <= in_data.temp_pin;
    end
    if (emit) begin
      out_data_r.measured      <= meas_r;
      out_data_r.battery_volts <= fb_r;
      out_data_r.chip_temp     <= ft_r;
      out_data_r.beeper        <= beep_r;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bla_checker.sv */
// ----------------------------------------------------------------------------
// bla_checker: port-level assertions for the battery low voltage alarm
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module bla_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire bla_pkg::out_t out_data,
  input wire logic          cfg_ready
);

  // A waiting result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in work");

  // A new result only follows an item that was being worked on.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no item in work");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind battery_low_voltage_alarm bla_checker u_bla_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for battery_low_voltage_alarm
// Streams ticks through the block with random gaps on both channels.
// A scoreboard keeps its own tick counters, filters and alarm state, and
// compares every result with the reading that it predicts for that tick.
// Pin values on measurement ticks are steered so that the filtered battery
// voltage settles inside the alarm band, above the release level or at or below
// 7 V, and the run sweeps several threshold and scale settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEASURE_DIV    = bla_pkg::MEASURE_DIVIDE_DEF;
  localparam int STARTUP        = bla_pkg::STARTUP_TICKS_DEF;
  localparam int BATT_OFFSET    = 338;     // 0.33 V in Q.10
  localparam int BATT_LOW       = 7168;    // 7 V in Q.10
  localparam int HYST           = 205;     // 0.2 V in Q.10
  localparam int TEMP_OFFSET    = 4464;    // 279 degrees in Q.4
  localparam int TEMP_LIFT      = 327680;
  localparam int ALARM_SAT      = 20;
  localparam int REPORT_LIMIT   = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {DRIVE_BAND, DRIVE_HIGH, DRIVE_LOW, DRIVE_NOISE} drive_mode_t;

  class alarm_tracker;
    logic [15:0]   threshold;
    logic [15:0]   scale;
    int            prescale;
    int            startup;
    int            filt_batt;
    int            filt_temp;
    int            alarm_cnt;
    bit            beep;
    bla_pkg::out_t expected_readings[$];
    int            results_seen;
    int            errors;

    function new();
      threshold    = bla_pkg::THRESHOLD_RST;
      scale        = bla_pkg::SCALE_RST;
      prescale     = 0;
      startup      = 0;
      filt_batt    = 0;
      filt_temp    = 0;
      alarm_cnt    = 0;
      beep         = 1'b0;
      results_seen = 0;
      errors       = 0;
    endfunction

    function void apply_register(logic [bla_pkg::CFG_IDX_W-1:0] idx,
                                 logic [bla_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bla_pkg::CFG_ALARM_THRESHOLD: threshold = val;
        bla_pkg::CFG_VOLTAGE_SCALE:   scale = val;
        default: ;
      endcase
    endfunction

    // The startup counter saturates one above the startup length, so the
    // comparison below holds for every tick after the startup window.
    function bit measures_next();
      return (prescale + 1 >= MEASURE_DIV) && (startup + 1 > STARTUP);
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function void note_tick(bla_pkg::in_t d);
      bit            take;
      logic [47:0]   prod;
      int            sample_b;
      int            sample_t;
      int            num;
      bla_pkg::out_t r;
      take = measures_next();
      prescale++;
      if (startup <= STARTUP) startup++;
      if (prescale >= MEASURE_DIV) prescale = 0;
      if (take) begin
        prod = 48'(d.battery_pin) * 48'(scale);
        sample_b = int'((prod + 48'd32768) >> 16) + BATT_OFFSET;
        if (sample_b > 65535) sample_b = 65535;
        filt_batt = (4 * filt_batt + sample_b + 2) / 5;
        sample_t = int'((32'(d.temp_pin) * 32'd25 + 32'd32) >> 6) - TEMP_OFFSET;
        num = 4 * filt_temp + sample_t + 2 + TEMP_LIFT;
        filt_temp = num / 5 - 65536;
        if (filt_batt > BATT_LOW && filt_batt < int'(threshold)) begin
          if (alarm_cnt < ALARM_SAT) alarm_cnt++;
          if (alarm_cnt >= ALARM_SAT) beep = ~beep;
        end else if (filt_batt > int'(threshold) + HYST) begin
          alarm_cnt = 0;
          beep = 1'b0;
        end
      end
      r.measured      = take;
      r.battery_volts = 16'(filt_batt);
      r.chip_temp     = 16'(filt_temp);
      r.beeper        = beep;
      expected_readings.push_back(r);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("ERROR: result %0d: %s", results_seen, msg);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) flag($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    function void check_result(bla_pkg::out_t got);
      bla_pkg::out_t want;
      results_seen++;
      if (expected_readings.size() == 0) begin
        flag("result with no tick outstanding");
        return;
      end
      want = expected_readings.pop_front();
      compare_field("measured", want.measured, got.measured);
      compare_field("battery_volts", want.battery_volts, got.battery_volts);
      compare_field("chip_temp", want.chip_temp, got.chip_temp);
      compare_field("beeper", want.beeper, got.beeper);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  bla_pkg::in_t                   in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  bla_pkg::out_t                  out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bla_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bla_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  alarm_tracker   tracker;
  bit             calm = 1'b0;
  drive_mode_t    mode = DRIVE_NOISE;
  int             target = 0;
  int             run_left = 0;
  bla_pkg::in_t   directed_q[$];
  int             quiet = 0;

  battery_low_voltage_alarm uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit stall_roll();
    return !calm && ($urandom_range(99) < 32);
  endfunction

  always @(negedge clk) begin
    out_ready <= !stall_roll();
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Battery pin that makes the battery sample land near the given voltage.
  function automatic logic [15:0] pin_for(int volts);
    longint span;
    if (tracker.scale == 0) return 16'($urandom_range(65535));
    span = ((longint'(volts - BATT_OFFSET) <<< 16) + longint'(tracker.scale) / 2) /
           longint'(tracker.scale);
    if (span > 65535) span = 65535;
    return 16'(span);
  endfunction

  // Pins of the next tick: random, but a measurement tick takes the directed
  // pins first, then a battery pin on a run's target (random in noise mode).
  function automatic bla_pkg::in_t pick_tick();
    bla_pkg::in_t d;
    int           roll;
    int           hi;
    d.battery_pin = 16'($urandom_range(65535));
    d.temp_pin    = 16'($urandom_range(65535));
    if (!tracker.measures_next()) return d;
    if (directed_q.size() != 0) return directed_q.pop_front();
    if (run_left == 0) begin
      run_left = $urandom_range(40, 5);
      roll = $urandom_range(99);
      if (roll < 45) mode = DRIVE_BAND;
      else if (roll < 70) mode = DRIVE_HIGH;
      else if (roll < 80) mode = DRIVE_LOW;
      else mode = DRIVE_NOISE;
      case (mode)
        DRIVE_BAND: begin
          hi = int'(tracker.threshold) - 1;
          if (hi <= BATT_LOW) mode = DRIVE_NOISE;
          else target = $urandom_range(hi, BATT_LOW + 1);
        end
        DRIVE_HIGH: begin
          target = int'(tracker.threshold) + HYST + 1 + $urandom_range(3000);
          if (target > 65535) target = 65535;
        end
        DRIVE_LOW: target = $urandom_range(BATT_LOW, BATT_OFFSET);
        default: ;
      endcase
    end
    run_left--;
    case (mode)
      DRIVE_NOISE: ;
      DRIVE_HIGH:  d.battery_pin = ($urandom_range(3) == 0) ? 16'hFFFF : pin_for(target);
      default:     d.battery_pin = pin_for(target);
    endcase
    return d;
  endfunction

  task automatic send_tick(input bla_pkg::in_t d);
    @(negedge clk);
    while (stall_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    tracker.note_tick(d);
  endtask

  task automatic set_register(input logic [bla_pkg::CFG_IDX_W-1:0] idx,
                              input logic [bla_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.apply_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Holds the sender off until every reading already owed has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic run_measurements(input int count);
    int done;
    done = 0;
    while (done < count) begin
      if (tracker.measures_next()) done++;
      send_tick(pick_tick());
    end
  endtask

  initial begin
    tracker = new();
    directed_q.push_back('{16'h0000, 16'h0000});
    directed_q.push_back('{16'hFFFF, 16'hFFFF});
    directed_q.push_back('{16'h0000, 16'hFFFF});
    directed_q.push_back('{16'hFFFF, 16'h0000});
    directed_q.push_back('{16'h8000, 16'h8000});
    directed_q.push_back('{16'h7FFF, 16'h7FFF});
    directed_q.push_back('{16'h0001, 16'h0001});
    directed_q.push_back('{16'hFFFE, 16'hFFFE});
    directed_q.push_back('{16'hAAAA, 16'h5555});
    directed_q.push_back('{16'h5555, 16'hAAAA});
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Writes to indexes past the last register must leave the settings alone.
    set_register(8'd2, 16'($urandom));
    set_register(8'hFF, 16'($urandom));
    send_tick('{16'hFFFF, 16'hFFFF});
    send_tick('{16'h0000, 16'h0000});
    send_tick('{16'hFFFF, 16'h0000});
    send_tick('{16'h0000, 16'hFFFF});
    run_measurements(1);

    for (int phase = 1; phase <= 8; phase++) begin
      drain();
      case (phase)
        1: begin
          set_register(bla_pkg::CFG_ALARM_THRESHOLD, 16'hFFFF);
          set_register(bla_pkg::CFG_VOLTAGE_SCALE, 16'hFFFF);
        end
        2: begin
          set_register(bla_pkg::CFG_ALARM_THRESHOLD, 16'h0000);
          set_register(bla_pkg::CFG_VOLTAGE_SCALE, 16'h0000);
        end
        3: begin
          set_register(bla_pkg::CFG_ALARM_THRESHOLD, bla_pkg::THRESHOLD_RST);
          set_register(bla_pkg::CFG_VOLTAGE_SCALE, bla_pkg::SCALE_RST);
        end
        5: begin
          set_register(bla_pkg::CFG_ALARM_THRESHOLD, 16'($urandom));
          set_register(bla_pkg::CFG_VOLTAGE_SCALE, 16'($urandom));
        end
        6: begin
          // Threshold at 7 V leaves the alarm band empty.
          set_register(bla_pkg::CFG_ALARM_THRESHOLD, 16'(BATT_LOW));
          set_register(bla_pkg::CFG_VOLTAGE_SCALE, bla_pkg::SCALE_RST);
        end
        default: begin
          set_register(bla_pkg::CFG_ALARM_THRESHOLD, 16'($urandom_range(14000, 7400)));
          set_register(bla_pkg::CFG_VOLTAGE_SCALE, 16'($urandom_range(65535, 30000)));
        end
      endcase
      set_register(8'($urandom_range(255, 2)), 16'($urandom));
      calm = (phase == 3);
      run_left = 0;
      run_measurements(1);
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bla_pkg.sv
hw/rtl/bla_mul.sv
hw/rtl/bla_tick.sv
hw/rtl/battery_low_voltage_alarm.sv
hw/rtl/bla_checker.sv
verif/tb_top.sv
